FILE: sv/bcs_pkg.sv
// Package for the button click sequencer: phase codes, register indexes,
// and the item and result structs shared by the stages. No dependencies.
package bcs_pkg;

	// Phase of the click sequence
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PRESS = 2'd1,
		PH_GAP   = 2'd2,
		PH_BLOCK = 2'd3
	} phase_t;

	// Item kind carried on the input tuser bit
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRESS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAP   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK = 2'd2;

	// Field widths fixed by the interface
	localparam int unsigned FIELD_TIME_BITS = 16;
	localparam int unsigned COUNT_BITS      = 8;
	localparam int unsigned IN_DATA_BITS    = 56;
	localparam int unsigned OUT_DATA_BITS   = 16;

	// One input item
	typedef struct packed {
		logic                       command;
		logic [COUNT_BITS-1:0]      click_count;
		logic [FIELD_TIME_BITS-1:0] press_time;
		logic [FIELD_TIME_BITS-1:0] gap_time;
		logic [FIELD_TIME_BITS-1:0] block_time;
	} item_t;

	// One result item
	typedef struct packed {
		logic                  pin_level;
		logic                  accepted;
		logic                  finished;
		phase_t                phase;
		logic [COUNT_BITS-1:0] clicks_left;
	} result_t;

endpackage

FILE: sv/bcs_in_stage.sv
// Input register stage of the button click sequencer.
// Depends on bcs_pkg for the item struct.
module bcs_in_stage import bcs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  item_valid_s1,
	input  logic  item_ready_s1,
	output item_t item_s1
);

	logic valid_q;

	// Take a new item whenever the stage is empty or draining
	assign in_ready      = !valid_q || item_ready_s1;
	assign item_valid_s1 = valid_q;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Capture the item payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: sv/bcs_core.sv
// Sequencer state, default registers and result register of the button
// click sequencer. Depends on bcs_pkg for phase codes and item structs.
module bcs_core import bcs_pkg::*; #(
	parameter int unsigned TIME_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [FIELD_TIME_BITS-1:0] cfg_data,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  item_t                      item,
	output logic                       res_valid,
	input  logic                       res_ready,
	output result_t                    res
);

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic [TIME_BITS-1:0]  def_press_q, def_gap_q, def_block_q;
	phase_t                phase_q, phase_d;
	logic [COUNT_BITS-1:0] rem_q, rem_d, rem_dec;
	logic [TIME_BITS-1:0]  press_q, press_d, gap_q, gap_d, block_q, block_d;
	logic [TIME_BITS-1:0]  elapsed_q, elapsed_d, elapsed_inc, dur;
	logic                  clicked_q, clicked_d;
	logic                  level_q, level_d;
	logic                  acc_d, fin_d;
	logic                  out_valid_q;
	logic                  adv;
	logic [31:0]           pt_w, gt_w, bt_w, cfg_w;
	logic [TIME_BITS-1:0]  pt, gt, bt, cfg_val;

	// Resize the fixed-width fields to the internal time width
	assign pt_w    = {16'd0, item.press_time};
	assign gt_w    = {16'd0, item.gap_time};
	assign bt_w    = {16'd0, item.block_time};
	assign cfg_w   = {16'd0, cfg_data};
	assign pt      = pt_w[TIME_BITS-1:0];
	assign gt      = gt_w[TIME_BITS-1:0];
	assign bt      = bt_w[TIME_BITS-1:0];
	assign cfg_val = cfg_w[TIME_BITS-1:0];

	assign item_ready = !out_valid_q || res_ready;
	assign adv        = item_valid && item_ready;
	assign res_valid  = out_valid_q;

	// Default time registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_press_q <= '0;
			def_gap_q   <= '0;
			def_block_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESS: def_press_q <= cfg_val;
				REG_GAP:   def_gap_q   <= cfg_val;
				REG_BLOCK: def_block_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// Next state for one item: start command or tick
	always_comb begin
		phase_d   = phase_q;
		rem_d     = rem_q;
		press_d   = press_q;
		gap_d     = gap_q;
		block_d   = block_q;
		elapsed_d = elapsed_q;
		clicked_d = clicked_q;
		level_d   = level_q;
		acc_d     = 1'b0;
		fin_d     = 1'b0;
		rem_dec   = rem_q - 8'd1;

		elapsed_inc = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + TIME_BITS'(1);
		case (phase_q)
			PH_PRESS: dur = press_q;
			PH_GAP:   dur = gap_q;
			default:  dur = block_q;
		endcase

		if (item.command == CMD_START) begin
			if (phase_q == PH_IDLE && item.click_count != '0) begin
				rem_d     = item.click_count;
				press_d   = (pt != '0) ? pt : def_press_q;
				gap_d     = (gt != '0) ? gt : def_gap_q;
				block_d   = (bt != '0) ? bt : def_block_q;
				phase_d   = PH_PRESS;
				elapsed_d = '0;
				level_d   = 1'b0;
				clicked_d = 1'b1;
				acc_d     = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			elapsed_d = elapsed_inc;
			if (dur == '0) begin
				phase_d = PH_IDLE;
			end else if (elapsed_inc >= dur) begin
				elapsed_d = '0;
				unique case (phase_q)
					PH_PRESS: begin
						level_d = 1'b1;
						rem_d   = rem_dec;
						if (rem_dec != '0) begin
							phase_d = PH_GAP;
						end else if (block_q != '0) begin
							phase_d = PH_BLOCK;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_GAP: begin
						if (rem_q != '0) begin
							phase_d   = PH_PRESS;
							level_d   = 1'b0;
							clicked_d = 1'b1;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
			// Drop to idle: report a clicked sequence and clear the times
			if (phase_d == PH_IDLE) begin
				fin_d     = clicked_d;
				clicked_d = 1'b0;
				elapsed_d = '0;
				press_d   = '0;
				gap_d     = '0;
				block_d   = '0;
			end
		end
	end

	// Sequencer state, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			rem_q     <= '0;
			press_q   <= '0;
			gap_q     <= '0;
			block_q   <= '0;
			elapsed_q <= '0;
			clicked_q <= 1'b0;
			level_q   <= 1'b1;
		end else if (adv) begin
			phase_q   <= phase_d;
			rem_q     <= rem_d;
			press_q   <= press_d;
			gap_q     <= gap_d;
			block_q   <= block_d;
			elapsed_q <= elapsed_d;
			clicked_q <= clicked_d;
			level_q   <= level_d;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= item_valid;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res.pin_level   <= level_d;
			res.accepted    <= acc_d;
			res.finished    <= fin_d;
			res.phase       <= phase_d;
			res.clicks_left <= rem_d;
		end
	end

endmodule

FILE: sv/button_click_sequencer_top.sv
// Top level of the button click sequencer: input register stage and core.
// Depends on bcs_pkg, bcs_in_stage and bcs_core.
//
//   channel | direction | handshake                     | payload
//   s_axis  | in        | s_axis_tvalid / s_axis_tready | tuser command, tdata times
//   m_axis  | out       | m_axis_tvalid / m_axis_tready | tdata result flags and phase
//   cfg     | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item per clock sustained while m_axis_tready is high; each item taken
// passes through the input register and then the result register, which
// holds its result for m_axis.
// Reset (arst_n low) returns the sequencer to idle with the line released
// and clears the default times. A stalled m_axis holds its result while
// the input register takes one more item; cfg is always ready.
module button_click_sequencer_top import bcs_pkg::*; #(
	parameter int unsigned TIME_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// [0] command
	input  logic                       s_axis_tuser,
	// [7:0] click_count, [23:8] press_time, [39:24] gap_time, [55:40] block_time
	input  logic [IN_DATA_BITS-1:0]    s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [0] pin_level, [1] accepted, [2] finished, [4:3] phase,
	// [12:5] clicks_left, [15:13] zero
	output logic [OUT_DATA_BITS-1:0]   m_axis_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [FIELD_TIME_BITS-1:0] cfg_data
);

	item_t   in_item, item_s1;
	logic    item_valid_s1, item_ready_s1;
	result_t res;

	// Unpack the input item
	assign in_item.command     = s_axis_tuser;
	assign in_item.click_count = s_axis_tdata[7:0];
	assign in_item.press_time  = s_axis_tdata[23:8];
	assign in_item.gap_time    = s_axis_tdata[39:24];
	assign in_item.block_time  = s_axis_tdata[55:40];

	assign cfg_ready = 1'b1;

	bcs_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_item       (in_item),
		.item_valid_s1 (item_valid_s1),
		.item_ready_s1 (item_ready_s1),
		.item_s1       (item_s1)
	);

	bcs_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid_s1),
		.item_ready (item_ready_s1),
		.item       (item_s1),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	// Pack the result item
	assign m_axis_tdata = {3'b000, res.clicks_left, res.phase, res.finished,
		res.accepted, res.pin_level};

endmodule

FILE: sv/bcs_checker.sv
// Port-level checks for the button click sequencer, bound to the top level.
// Depends on bcs_pkg for the phase codes.
module bcs_checker import bcs_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

	logic       pin, acc, fin;
	logic [1:0] ph;
	logic [7:0] left;

	assign pin  = m_axis_tdata[0];
	assign acc  = m_axis_tdata[1];
	assign fin  = m_axis_tdata[2];
	assign ph   = m_axis_tdata[4:3];
	assign left = m_axis_tdata[12:5];

	// A taken start always lands in the pressing phase with the line low
	a_accept_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && acc |-> ph == PH_PRESS && !pin && left != '0)
		else $error("accepted start not in pressing phase");

	// Completion is only reported on the return to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && fin |-> ph == PH_IDLE && !acc)
		else $error("finished pulse outside idle");

	// The gap phase has the line released and clicks still to do
	a_gap_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ph == PH_GAP |-> pin && left != '0)
		else $error("gap phase with line low or no clicks left");

	// The hold-off follows the last click with the line released
	a_block_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ph == PH_BLOCK |-> pin && left == '0)
		else $error("hold-off phase with clicks left or line low");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result item changed");

endmodule

bind button_click_sequencer_top bcs_checker u_bcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
